// ===== src/rgb_led_matrix_pwm_scanner_defines.svh =====
// ---------------------------------------------------------------------------
// rgb_led_matrix_pwm_scanner_defines
// Assertion macros shared by the LED matrix scanner RTL.
// ---------------------------------------------------------------------------
`ifndef RGB_LED_MATRIX_PWM_SCANNER_DEFINES_SVH
`define RGB_LED_MATRIX_PWM_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define RLMPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlmps: same-cycle check failed");

// Next-cycle implication, checked on i_clk, off while i_rst_n is low.
`define RLMPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlmps: next-cycle check failed");

`endif

// ===== src/rlmps_pkg.sv =====
// ---------------------------------------------------------------------------
// rlmps_pkg
// Constants, types and the PWM threshold table of the LED matrix scanner.
// ---------------------------------------------------------------------------
package rlmps_pkg;

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COLOR_W     = 6;
    localparam int POS_W       = 3;
    localparam int LEVEL_W     = 2;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    localparam logic [7:0] ROW_BIT0  = 8'h80;
    localparam logic [7:0] BYTE_OFF  = 8'hff;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

    typedef enum logic [1:0] {
        WORD_RED,
        WORD_GREEN,
        WORD_BLUE,
        WORD_OFF
    } t_word;

    // Minimum level that lights a colour in each of the 8 PWM frames.
    function automatic logic [LEVEL_W-1:0] level_for_frame(input logic [POS_W-1:0] frame);
        logic [LEVEL_W-1:0] thr;
        unique case (frame)
            3'd0:    thr = 2'd1;
            3'd1:    thr = 2'd2;
            3'd2:    thr = 2'd2;
            default: thr = 2'd3;
        endcase
        return thr;
    endfunction

endpackage

// ===== src/rlmps_ram.sv =====
// ---------------------------------------------------------------------------
// rlmps_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
module rlmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rgb_led_matrix_pwm_scanner.sv =====
// ---------------------------------------------------------------------------
// rgb_led_matrix_pwm_scanner
// 8x8 RGB LED matrix scanner, one pixel at a time, 8-frame PWM.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = 0 writes pixel_color to pixel_index in the frame
//   store; tuser = 1 scans the next pixel (column-major, rows inside columns).
//   Master stream: per scan request three 32-bit drive words, red, green,
//   blue; after the last pixel of a frame a fourth all-off word follows.
//   tlast marks the final word of each scan request.
//   Path: a scan is read from the frame store into the read stage at the
//   accepting edge; its words are built into the emitter once it is free.
//   Throughput: scans are paced by the word emitter, which sends one word a
//   cycle while tready is high; writes go in one per cycle while the read
//   stage is free. One scan waits in the read stage behind the emitter.
//   Reset: the frame store reads dark through per-pixel valid bits, so no
//   clearing pass runs; scan position and PWM frame return to zero.
//   Stall: a word held by a low tready stays unchanged; the read stage then
//   fills and tready on the slave side drops.
// ---------------------------------------------------------------------------
`include "rgb_led_matrix_pwm_scanner_defines.svh"

module rgb_led_matrix_pwm_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [5:0] pixel_index, [11:6] pixel_color, [15:12] zero
    input  logic [rlmps_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [0] cmd
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] red_rows, [15:8] blue_rows, [23:16] green_rows, [31:24] column_select
    output logic [rlmps_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);

    import rlmps_pkg::*;

    // scan position and PWM frame
    logic [POS_W-1:0]       r_row, n_row;
    logic [POS_W-1:0]       r_col, n_col;
    logic [POS_W-1:0]       r_frame, n_frame;
    logic [STORE_DEPTH-1:0] r_valid, n_valid;

    // read stage
    logic                   r_p1, n_p1;
    logic [POS_W-1:0]       r_p1_row, n_p1_row;
    logic [POS_W-1:0]       r_p1_col, n_p1_col;
    logic [LEVEL_W-1:0]     r_p1_thr, n_p1_thr;
    logic                   r_p1_fend, n_p1_fend;
    logic                   r_p1_vbit, n_p1_vbit;

    // word emitter
    logic                   r_e_vld, n_e_vld;
    t_word                  r_e_idx, n_e_idx;
    logic [7:0]             r_rv, n_rv;
    logic [7:0]             r_gv, n_gv;
    logic [7:0]             r_bv, n_bv;
    logic [7:0]             r_csel, n_csel;
    logic                   r_fend, n_fend;

    logic                   s_acc;
    logic                   is_scan;
    logic                   is_write;
    logic                   m_acc;
    logic                   e_done;
    logic                   load;
    logic [ADDR_W-1:0]      scan_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COLOR_W-1:0]     wr_color;
    logic [COLOR_W-1:0]     ram_rdata;
    logic [COLOR_W-1:0]     color;
    logic [7:0]             row_on;
    logic                   row_wrap;
    logic                   col_wrap;

    assign wr_addr   = i_s_axis_tdata[ADDR_W-1:0];
    assign wr_color  = i_s_axis_tdata[ADDR_W +: COLOR_W];
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign is_scan   = s_acc && (i_s_axis_tuser == CMD_SCAN);
    assign is_write  = s_acc && (i_s_axis_tuser == CMD_WRITE);
    assign m_acc     = o_m_axis_tvalid && i_m_axis_tready;
    assign e_done    = m_acc && o_m_axis_tlast;
    assign load      = r_p1 && (!r_e_vld || e_done);
    assign o_s_axis_tready = !r_p1 || load;

    assign scan_addr = ADDR_W'(int'(r_row) * COLS + int'(r_col));
    assign row_wrap  = (int'(r_row) + 1 >= ROWS);
    assign col_wrap  = (int'(r_col) + 1 >= COLS);

    rlmps_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (is_write),
        .i_waddr (wr_addr),
        .i_wdata (wr_color),
        .i_re    (is_scan),
        .i_raddr (scan_addr),
        .o_rdata (ram_rdata)
    );

    // never-written pixels read dark
    assign color  = r_p1_vbit ? ram_rdata : COLOR_W'(0);
    assign row_on = ~(ROW_BIT0 >> r_p1_row);

    always_comb begin
        n_row     = r_row;
        n_col     = r_col;
        n_frame   = r_frame;
        n_valid   = r_valid;
        n_p1      = r_p1;
        n_p1_row  = r_p1_row;
        n_p1_col  = r_p1_col;
        n_p1_thr  = r_p1_thr;
        n_p1_fend = r_p1_fend;
        n_p1_vbit = r_p1_vbit;
        n_e_vld   = r_e_vld;
        n_e_idx   = r_e_idx;
        n_rv      = r_rv;
        n_gv      = r_gv;
        n_bv      = r_bv;
        n_csel    = r_csel;
        n_fend    = r_fend;

        if (is_write) begin
            n_valid[wr_addr] = 1'b1;
        end

        // word emitter advance
        if (m_acc) begin
            unique case (r_e_idx)
                WORD_RED:   n_e_idx = WORD_GREEN;
                WORD_GREEN: n_e_idx = WORD_BLUE;
                WORD_BLUE:  n_e_idx = WORD_OFF;
                default:    n_e_idx = WORD_RED;
            endcase
            if (e_done) begin
                n_e_vld = 1'b0;
            end
        end

        if (load) begin
            n_e_vld = 1'b1;
            n_e_idx = WORD_RED;
            n_rv    = (color[5:4] >= r_p1_thr) ? row_on : BYTE_OFF;
            n_gv    = (color[3:2] >= r_p1_thr) ? row_on : BYTE_OFF;
            n_bv    = (color[1:0] >= r_p1_thr) ? row_on : BYTE_OFF;
            n_csel  = 8'(9'd1 << r_p1_col);
            n_fend  = r_p1_fend;
            n_p1    = 1'b0;
        end

        if (is_scan) begin
            n_p1      = 1'b1;
            n_p1_row  = r_row;
            n_p1_col  = r_col;
            n_p1_thr  = level_for_frame(r_frame);
            n_p1_fend = row_wrap && col_wrap;
            n_p1_vbit = r_valid[scan_addr];
            if (!row_wrap) begin
                n_row = r_row + POS_W'(1);
            end else begin
                n_row = '0;
                n_col = col_wrap ? '0 : r_col + POS_W'(1);
                if (col_wrap) begin
                    n_frame = r_frame + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_frame <= '0;
            r_valid <= '0;
            r_p1    <= 1'b0;
            r_e_vld <= 1'b0;
            r_e_idx <= WORD_RED;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_frame <= n_frame;
            r_valid <= n_valid;
            r_p1    <= n_p1;
            r_e_vld <= n_e_vld;
            r_e_idx <= n_e_idx;
        end
        r_p1_row  <= n_p1_row;
        r_p1_col  <= n_p1_col;
        r_p1_thr  <= n_p1_thr;
        r_p1_fend <= n_p1_fend;
        r_p1_vbit <= n_p1_vbit;
        r_rv      <= n_rv;
        r_gv      <= n_gv;
        r_bv      <= n_bv;
        r_csel    <= n_csel;
        r_fend    <= n_fend;
    end

    // word select
    always_comb begin
        o_m_axis_tvalid = r_e_vld;
        unique case (r_e_idx)
            WORD_RED: begin
                o_m_axis_tdata = {r_csel, BYTE_OFF, BYTE_OFF, r_rv};
                o_m_axis_tlast = 1'b0;
            end
            WORD_GREEN: begin
                o_m_axis_tdata = {r_csel, r_gv, BYTE_OFF, BYTE_OFF};
                o_m_axis_tlast = 1'b0;
            end
            WORD_BLUE: begin
                o_m_axis_tdata = {r_csel, BYTE_OFF, r_bv, BYTE_OFF};
                o_m_axis_tlast = !r_fend;
            end
            default: begin
                o_m_axis_tdata = {BYTE_ZERO, BYTE_OFF, BYTE_OFF, BYTE_OFF};
                o_m_axis_tlast = 1'b1;
            end
        endcase
    end

    `RLMPS_ASSERT_NOW(a_off_word_at_frame_end, r_e_vld && (r_e_idx == WORD_OFF), r_fend)
    `RLMPS_ASSERT_NOW(a_col_onehot, o_m_axis_tvalid && !o_m_axis_tlast,
                      $onehot(o_m_axis_tdata[31:24]))
    `RLMPS_ASSERT_NOW(a_stall_only_when_full, !o_s_axis_tready, r_p1 && r_e_vld)
    `RLMPS_ASSERT_NEXT(a_read_stage_holds, r_p1 && !load, r_p1 && $stable(r_p1_row))

endmodule
